[rtl/request_chunk_reassembler_unit_assert.svh]
// Assertion macros for the request chunk reassembler.
`ifndef REQUEST_CHUNK_REASSEMBLER_UNIT_ASSERT_SVH
`define REQUEST_CHUNK_REASSEMBLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rcr_pkg.sv]
// Types and constants shared by the request chunk reassembler files.
package rcr_pkg;

  // Result event codes
  typedef enum logic [2:0] {
    EV_BYTE        = 3'd0,
    EV_BAD_VERSION = 3'd1,
    EV_BUSY        = 3'd2,
    EV_SEQ_ABORT   = 3'd3,
    EV_ABANDON     = 3'd4
  } rcr_event_e;

  // Role of a message byte
  typedef enum logic [1:0] {
    ROLE_SIZE     = 2'd0,
    ROLE_COMMAND  = 2'd1,
    ROLE_PAYLOAD  = 2'd2,
    ROLE_CHECKSUM = 2'd3
  } rcr_role_e;

  // Input word kind
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Configuration register map
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_PROTOCOL_VERSION = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT_TICKS    = 3'd4;

  localparam logic [2:0]  PROTOCOL_VERSION_RST = 3'd1;
  localparam logic [15:0] TIMEOUT_TICKS_RST    = 16'd1000;
  localparam logic [15:0] AGE_MAX              = 16'hFFFF;

  // Payload length in the size byte plus command, checksum and size byte itself
  localparam logic [8:0] FRAME_OVERHEAD = 9'd3;

endpackage

[rtl/rcr_if.sv]
// Valid/ready channel interfaces for the chunk input and the result output.
interface rcr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] chunk_byte;
  logic       chunk_first;

  modport source (output valid, output action, output chunk_byte, output chunk_first,
                  input ready);
  modport sink   (input valid, input action, input chunk_byte, input chunk_first,
                  output ready);
endinterface

interface rcr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] out_byte;
  logic [1:0] byte_role;
  logic       last;
  logic       crc_ok;

  modport source (output valid, output event_res, output out_byte, output byte_role,
                  output last, output crc_ok, input ready);
  modport sink   (input valid, input event_res, input out_byte, input byte_role,
                  input last, input crc_ok, output ready);
endinterface

[rtl/request_chunk_reassembler_unit.sv]
// Top level of the request chunk reassembler: chunk parsing and message output.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+-------------------------------------------
//  in_i     | in  | valid/ready   | action, chunk_byte, chunk_first
//  out_o    | out | valid/ready   | event_res, out_byte, byte_role, last, crc_ok
//  apb      | in  | psel/penable  | protocol_version @0x0, timeout_ticks @0x4
//
// One word is accepted per cycle while in_i.ready is high; its result, if any,
// appears in the output register on the next cycle. State update and result are
// compares, 9/16-bit counters and an XOR between the state and output registers.
// in_i.ready drops only while a result sits in the output register unread.
// rst_ni clears the control state and loads the register reset values.
module request_chunk_reassembler_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rcr_in_if.sink                     in_i,
  rcr_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Configuration registers
  logic [2:0]  protocol_version_q;
  logic [15:0] timeout_ticks_q;

  // Reassembly state
  logic        receiving_q, receiving_d;
  logic        chunk_accepted_q, chunk_accepted_d;
  logic        awaiting_size_q, awaiting_size_d;
  logic [8:0]  expected_total_q, expected_total_d;
  logic [8:0]  received_count_q, received_count_d;
  logic [3:0]  last_seq_q, last_seq_d;
  logic [7:0]  crc_acc_q, crc_acc_d;
  logic [15:0] age_q, age_d;

  // Result register
  logic                out_valid_q;
  rcr_pkg::rcr_event_e out_event_q;
  logic [7:0]          out_byte_q;
  rcr_pkg::rcr_role_e  out_role_q;
  logic                out_last_q;
  logic                out_ok_q;

  logic                res_valid;
  rcr_pkg::rcr_event_e res_event;
  logic [7:0]          res_byte;
  rcr_pkg::rcr_role_e  res_role;
  logic                res_last;
  logic                res_ok;

  logic       in_accept;
  logic [3:0] hdr_seq;
  logic       hdr_start;
  logic [2:0] hdr_ver;
  logic [7:0] b;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  assign b         = in_i.chunk_byte;
  assign hdr_seq   = b[3:0];
  assign hdr_start = b[4];
  assign hdr_ver   = b[7:5];

  // APB configuration port
  assign pready = 1'b1;

  always_comb begin
    case (paddr)
      rcr_pkg::ADDR_PROTOCOL_VERSION: prdata = {29'd0, protocol_version_q};
      rcr_pkg::ADDR_TIMEOUT_TICKS:    prdata = {16'd0, timeout_ticks_q};
      default:                        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protocol_version_q <= rcr_pkg::PROTOCOL_VERSION_RST;
      timeout_ticks_q    <= rcr_pkg::TIMEOUT_TICKS_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr == rcr_pkg::ADDR_PROTOCOL_VERSION) begin
        protocol_version_q <= pwdata[2:0];
      end
      if (paddr == rcr_pkg::ADDR_TIMEOUT_TICKS) begin
        timeout_ticks_q <= pwdata[15:0];
      end
    end
  end

  // Next state and result for the word at the input
  always_comb begin
    receiving_d      = receiving_q;
    chunk_accepted_d = chunk_accepted_q;
    awaiting_size_d  = awaiting_size_q;
    expected_total_d = expected_total_q;
    received_count_d = received_count_q;
    last_seq_d       = last_seq_q;
    crc_acc_d        = crc_acc_q;
    age_d            = age_q;
    res_valid        = 1'b0;
    res_event        = rcr_pkg::EV_BYTE;
    res_byte         = 8'd0;
    res_role         = rcr_pkg::ROLE_SIZE;
    res_last         = 1'b0;
    res_ok           = 1'b0;

    if (in_i.action == rcr_pkg::ACT_TICK) begin
      // time tick: age the partial message, saturating
      if (receiving_q && age_q != rcr_pkg::AGE_MAX) begin
        age_d = age_q + 16'd1;
      end
    end else if (in_i.chunk_first) begin
      // chunk header
      if (hdr_ver != protocol_version_q) begin
        chunk_accepted_d = 1'b0;
        res_valid        = 1'b1;
        res_event        = rcr_pkg::EV_BAD_VERSION;
      end else if (hdr_start) begin
        if (receiving_q && age_q <= timeout_ticks_q) begin
          chunk_accepted_d = 1'b0;
          res_valid        = 1'b1;
          res_event        = rcr_pkg::EV_BUSY;
        end else begin
          receiving_d      = 1'b1;
          chunk_accepted_d = 1'b1;
          awaiting_size_d  = 1'b1;
          expected_total_d = 9'd0;
          received_count_d = 9'd0;
          crc_acc_d        = 8'd0;
          age_d            = 16'd0;
          last_seq_d       = hdr_seq;
          if (receiving_q) begin
            res_valid = 1'b1;
            res_event = rcr_pkg::EV_ABANDON;
          end
        end
      end else if (!receiving_q) begin
        chunk_accepted_d = 1'b0;
      end else if (hdr_seq != last_seq_q + 4'd1) begin
        receiving_d      = 1'b0;
        chunk_accepted_d = 1'b0;
        awaiting_size_d  = 1'b0;
        res_valid        = 1'b1;
        res_event        = rcr_pkg::EV_SEQ_ABORT;
      end else begin
        last_seq_d       = hdr_seq;
        chunk_accepted_d = 1'b1;
      end
    end else if (receiving_q && chunk_accepted_q) begin
      // data byte of an accepted chunk
      if (awaiting_size_q) begin
        awaiting_size_d  = 1'b0;
        expected_total_d = {1'b0, b} + rcr_pkg::FRAME_OVERHEAD;
        received_count_d = 9'd1;
        crc_acc_d        = b;
        res_valid        = 1'b1;
        res_byte         = b;
        res_role         = rcr_pkg::ROLE_SIZE;
      end else if (received_count_q >= expected_total_q) begin
        res_valid = 1'b0;
      end else if (received_count_q + 9'd1 == expected_total_q) begin
        received_count_d = expected_total_q;
        receiving_d      = 1'b0;
        chunk_accepted_d = 1'b0;
        awaiting_size_d  = 1'b0;
        res_valid        = 1'b1;
        res_byte         = b;
        res_role         = rcr_pkg::ROLE_CHECKSUM;
        res_last         = 1'b1;
        res_ok           = (crc_acc_q == b);
      end else begin
        crc_acc_d        = crc_acc_q ^ b;
        received_count_d = received_count_q + 9'd1;
        res_valid        = 1'b1;
        res_byte         = b;
        res_role         = (received_count_q == 9'd1) ? rcr_pkg::ROLE_COMMAND
                                                      : rcr_pkg::ROLE_PAYLOAD;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q      <= 1'b0;
      chunk_accepted_q <= 1'b0;
      awaiting_size_q  <= 1'b0;
      expected_total_q <= 9'd0;
      received_count_q <= 9'd0;
      last_seq_q       <= 4'd0;
      crc_acc_q        <= 8'd0;
      age_q            <= 16'd0;
    end else if (in_accept) begin
      receiving_q      <= receiving_d;
      chunk_accepted_q <= chunk_accepted_d;
      awaiting_size_q  <= awaiting_size_d;
      expected_total_q <= expected_total_d;
      received_count_q <= received_count_d;
      last_seq_q       <= last_seq_d;
      crc_acc_q        <= crc_acc_d;
      age_q            <= age_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid) begin
      out_event_q <= res_event;
      out_byte_q  <= res_byte;
      out_role_q  <= res_role;
      out_last_q  <= res_last;
      out_ok_q    <= res_ok;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = out_event_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.byte_role = out_role_q;
  assign out_o.last      = out_last_q;
  assign out_o.crc_ok    = out_ok_q;

  // Checks
`include "request_chunk_reassembler_unit_assert.svh"

  `RCR_ASSERT_IMPL(a_last_is_checksum, clk_i, rst_ni, out_valid_q && out_last_q, out_event_q == rcr_pkg::EV_BYTE && out_role_q == rcr_pkg::ROLE_CHECKSUM, "last flag on a word that is not a checksum byte")
  `RCR_ASSERT_IMPL(a_ok_needs_last, clk_i, rst_ni, out_valid_q && out_ok_q, out_last_q, "crc_ok set without last")
  `RCR_ASSERT_NEXT(a_tick_no_result, clk_i, rst_ni, in_accept && in_i.action == rcr_pkg::ACT_TICK, !out_valid_q, "a tick produced a result")
  `RCR_ASSERT_IMPL(a_idle_clean, clk_i, rst_ni, !receiving_q, !chunk_accepted_q && !awaiting_size_q, "chunk state left over while idle")

endmodule

[bench/rcr_result_checker.sv]
// Result checker for the request chunk reassembler: predicts each result word and compares.
`timescale 1ns / 1ps

module rcr_result_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rcr_in_if                          in_mon,
  rcr_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int unsigned                fail_cnt_o,
  output int unsigned                pending_o
);

  typedef struct packed {
    rcr_pkg::rcr_event_e ev;
    logic [7:0]          data;
    rcr_pkg::rcr_role_e  role;
    logic                last;
    logic                crc_ok;
  } msg_result_t;

  // Register copies, tracked from the config bus
  logic [2:0]  cfg_version;
  logic [15:0] cfg_timeout;

  // Reassembly state of the predictor
  logic        rx_active;
  logic        chunk_ok;
  logic        want_size;
  logic [8:0]  total_len;
  logic [8:0]  rx_count;
  logic [3:0]  prev_seq;
  logic [7:0]  xor_acc;
  logic [15:0] tick_age;

  msg_result_t expected_q[$];
  int unsigned fails;

  // Advance the reassembly state by one input word; returns 1 when a result word follows
  function automatic bit predict_word(input logic act, input logic [7:0] b,
                                      input logic first, output msg_result_t res);
    logic [3:0] seq;
    logic       was_active;
    res = '{ev: rcr_pkg::EV_BYTE, data: 8'h00, role: rcr_pkg::ROLE_SIZE,
            last: 1'b0, crc_ok: 1'b0};
    seq = b[3:0];
    if (act == rcr_pkg::ACT_TICK) begin
      if (rx_active && tick_age != rcr_pkg::AGE_MAX) tick_age++;
      return 1'b0;
    end
    // header byte: version, start flag, sequence
    if (first) begin
      if (b[7:5] != cfg_version) begin
        chunk_ok = 1'b0;
        res.ev = rcr_pkg::EV_BAD_VERSION;
        return 1'b1;
      end
      if (b[4]) begin
        if (rx_active && tick_age <= cfg_timeout) begin
          chunk_ok = 1'b0;
          res.ev = rcr_pkg::EV_BUSY;
          return 1'b1;
        end
        was_active = rx_active;
        rx_active = 1'b1;
        chunk_ok = 1'b1;
        want_size = 1'b1;
        total_len = '0;
        rx_count = '0;
        xor_acc = '0;
        tick_age = '0;
        prev_seq = seq;
        res.ev = rcr_pkg::EV_ABANDON;
        return was_active;
      end
      if (!rx_active) begin
        chunk_ok = 1'b0;
        return 1'b0;
      end
      if (seq != prev_seq + 4'd1) begin
        rx_active = 1'b0;
        chunk_ok = 1'b0;
        want_size = 1'b0;
        res.ev = rcr_pkg::EV_SEQ_ABORT;
        return 1'b1;
      end
      prev_seq = seq;
      chunk_ok = 1'b1;
      return 1'b0;
    end
    // data byte of an accepted chunk
    if (!rx_active || !chunk_ok) return 1'b0;
    res.data = b;
    if (want_size) begin
      want_size = 1'b0;
      total_len = {1'b0, b} + rcr_pkg::FRAME_OVERHEAD;
      rx_count = 9'd1;
      xor_acc = b;
      return 1'b1;
    end
    if (rx_count >= total_len) return 1'b0;
    if (rx_count + 9'd1 == total_len) begin
      res.role = rcr_pkg::ROLE_CHECKSUM;
      res.last = 1'b1;
      res.crc_ok = (xor_acc == b);
      rx_count = total_len;
      rx_active = 1'b0;
      chunk_ok = 1'b0;
      want_size = 1'b0;
      return 1'b1;
    end
    res.role = (rx_count == 9'd1) ? rcr_pkg::ROLE_COMMAND : rcr_pkg::ROLE_PAYLOAD;
    xor_acc = xor_acc ^ b;
    rx_count = rx_count + 9'd1;
    return 1'b1;
  endfunction

  // Watch both channels and the config bus
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    msg_result_t got;
    msg_result_t want;
    msg_result_t pred;
    if (!rst_ni) begin
      cfg_version = rcr_pkg::PROTOCOL_VERSION_RST;
      cfg_timeout = rcr_pkg::TIMEOUT_TICKS_RST;
      rx_active = 1'b0;
      chunk_ok = 1'b0;
      want_size = 1'b0;
      total_len = '0;
      rx_count = '0;
      prev_seq = '0;
      xor_acc = '0;
      tick_age = '0;
      expected_q.delete();
      fails = 0;
      fail_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          rcr_pkg::ADDR_PROTOCOL_VERSION: cfg_version = pwdata[2:0];
          rcr_pkg::ADDR_TIMEOUT_TICKS:    cfg_timeout = pwdata[15:0];
          default: ;
        endcase
      end
      // result word leaves the block: compare with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.ev     = rcr_pkg::rcr_event_e'(out_mon.event_res);
        got.data   = out_mon.out_byte;
        got.role   = rcr_pkg::rcr_role_e'(out_mon.byte_role);
        got.last   = out_mon.last;
        got.crc_ok = out_mon.crc_ok;
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word ev=%0d byte=%02h role=%0d last=%0b ok=%0b",
                   $time, out_mon.event_res, out_mon.out_byte, out_mon.byte_role,
                   out_mon.last, out_mon.crc_ok);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: mismatch expected ev=%0d byte=%02h role=%0d last=%0b ok=%0b",
                     $time, want.ev, want.data, want.role, want.last, want.crc_ok);
            $display("%0t:          actual   ev=%0d byte=%02h role=%0d last=%0b ok=%0b",
                     $time, out_mon.event_res, out_mon.out_byte, out_mon.byte_role,
                     out_mon.last, out_mon.crc_ok);
          end
        end
      end
      // input word accepted: predict its result
      if (in_mon.valid && in_mon.ready) begin
        if (predict_word(in_mon.action, in_mon.chunk_byte, in_mon.chunk_first, pred))
          expected_q.push_back(pred);
      end
      fail_cnt_o <= fails;
      pending_o <= expected_q.size();
    end
  end

endmodule

[bench/tb_top.sv]
// Top of the request chunk reassembler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [rcr_pkg::ADDR_W-1:0]  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  rcr_in_if  in_ch ();
  rcr_out_if out_ch ();

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned words_sent;
  int unsigned cycle_cnt;
  bit          idle_on;
  bit          hold_req;
  bit          hold_done;
  logic [2:0]  cur_version;

  always #1 clk_i = ~clk_i;

  request_chunk_reassembler_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rcr_result_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // Offer one word, with random idle cycles ahead of it, and wait until taken
  task automatic send_word(input logic act, input logic [7:0] b, input logic first);
    while (idle_on && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.chunk_byte  <= b;
    in_ch.chunk_first <= first;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(rcr_pkg::ACT_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic send_header(input logic start, input logic [3:0] seq, input logic [2:0] ver);
    send_word(rcr_pkg::ACT_BYTE, {ver, start, seq}, 1'b1);
  endtask

  task automatic send_data(input logic [7:0] b);
    send_word(rcr_pkg::ACT_BYTE, b, 1'b0);
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [rcr_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [2:0] ver, input logic [15:0] tmo);
    drain();
    apb_write(rcr_pkg::ADDR_PROTOCOL_VERSION, {29'd0, ver});
    apb_write(rcr_pkg::ADDR_TIMEOUT_TICKS, {16'd0, tmo});
    cur_version = ver;
  endtask

  // One message split over chunks; a broken one may carry a bad checksum, abort, drop a chunk or stop early
  task automatic send_message(input int unsigned size, input bit broken);
    logic [7:0]  body[$];
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [3:0]  seq;
    int unsigned idx;
    int unsigned run;
    sum = size[7:0];
    body.push_back(size[7:0]);
    for (int unsigned k = 0; k < size + 1; k++) begin
      b = 8'($urandom_range(255));
      sum = sum ^ b;
      body.push_back(b);
    end
    if (broken && $urandom_range(1) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    body.push_back(sum);
    seq = 4'($urandom_range(15));
    send_header(1'b1, seq, cur_version);
    idx = 0;
    while (idx < body.size()) begin
      run = $urandom_range(1, 6);
      while (run != 0 && idx < body.size()) begin
        if ($urandom_range(9) == 0) send_tick();
        send_data(body[idx]);
        idx++;
        run--;
      end
      if (idx < body.size()) begin
        seq = seq + 4'd1;
        if (broken && $urandom_range(3) == 0) begin
          case ($urandom_range(2))
            0: begin
              // out-of-order chunk aborts the message
              send_header(1'b0, seq + 4'($urandom_range(1, 15)), cur_version);
              return;
            end
            1: begin
              // chunk with a foreign version is dropped along with its data
              send_header(1'b0, seq, cur_version ^ 3'($urandom_range(1, 7)));
              repeat ($urandom_range(0, 2)) send_data(8'($urandom_range(255)));
            end
            default: return;
          endcase
        end
        send_header(1'b0, seq, cur_version);
      end
    end
    // trailing bytes past the checksum are dropped
    if ($urandom_range(7) == 0) send_data(8'($urandom_range(255)));
  endtask

  task automatic run_phase(input int unsigned quota);
    int unsigned stop_at;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      case ($urandom_range(9))
        0: send_word(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        1: repeat ($urandom_range(0, 12)) send_tick();
        default: begin
          if ($urandom_range(9) == 0) send_message($urandom_range(9, 40), $urandom_range(4) == 0);
          else send_message($urandom_range(0, 6), $urandom_range(4) == 0);
        end
      endcase
    end
  endtask

  // Result side: random back-pressure plus one long hold-off on request
  initial begin : result_sink
    int unsigned held;
    out_ch.ready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_ch.ready <= !(idle_on && $urandom_range(99) < 24);
    end
  end

  // Watchdog
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("request_chunk_reassembler_unit regression: fail");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= rcr_pkg::ACT_BYTE;
    in_ch.chunk_byte  <= 8'h00;
    in_ch.chunk_first <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= 32'd0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    words_sent  = 0;
    cur_version = rcr_pkg::PROTOCOL_VERSION_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: dropped words while idle, bad version, sequence wrap, good checksum
    send_data(8'hA5);
    send_header(1'b0, 4'd3, 3'd1);
    send_header(1'b1, 4'd0, 3'd0);
    send_header(1'b1, 4'd15, 3'd1);
    send_data(8'h00);
    send_data(8'hFF);
    send_header(1'b0, 4'd0, 3'd1);
    send_data(8'hFF);
    send_data(8'h12);
    // start while busy, foreign-version chunk mid message, bad checksum
    send_header(1'b1, 4'd4, 3'd1);
    send_data(8'h01);
    send_tick();
    send_header(1'b1, 4'd0, 3'd1);
    send_header(1'b0, 4'd5, 3'd7);
    send_data(8'h77);
    send_header(1'b0, 4'd5, 3'd1);
    send_data(8'h80);
    send_data(8'h01);
    send_data(8'h00);
    // sequence gap aborts
    send_header(1'b1, 4'd8, 3'd1);
    send_data(8'h02);
    send_header(1'b0, 4'd10, 3'd1);

    // start after the timeout abandons the partial message
    set_config(3'd0, 16'd0);
    send_header(1'b1, 4'd1, 3'd0);
    send_tick();
    send_header(1'b1, 4'd2, 3'd0);

    // the widest timeout keeps a partial message blocking new starts
    set_config(3'd7, 16'hFFFF);
    send_header(1'b1, 4'd6, 3'd7);
    send_data(8'h04);
    repeat (40) send_tick();
    send_header(1'b1, 4'd7, 3'd7);

    // random phases
    send_message(255, 1'b0);
    run_phase(200);

    set_config(3'd0, 16'd0);
    run_phase(200);

    set_config(3'($urandom_range(7)), 16'($urandom_range(1, 20)));
    idle_on = 1'b0;
    run_phase(200);
    idle_on = 1'b1;

    set_config(3'($urandom_range(7)), 16'($urandom_range(65535)));
    hold_req = 1'b1;
    send_message(40, 1'b0);
    run_phase(200);

    set_config(3'd5, 16'd3);
    run_phase(200);

    set_config(rcr_pkg::PROTOCOL_VERSION_RST, rcr_pkg::TIMEOUT_TICKS_RST);
    run_phase(200);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("request_chunk_reassembler_unit regression: pass");
    end else begin
      $display("request_chunk_reassembler_unit regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rcr_pkg.sv
rtl/rcr_if.sv
rtl/request_chunk_reassembler_unit.sv
bench/rcr_result_checker.sv
bench/tb_top.sv
